// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the button press classifier
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ===== rtl/bpc_pkg.sv =====
// ---------------------------------------------------------------------------
// bpc_pkg
// widths, register indexes, reset values and shared types
// ---------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned TICK_W     = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned NUM_BTN    = 2;

    // button slots
    localparam int unsigned BTN_RIGHT  = 0;
    localparam int unsigned BTN_LEFT   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_OFFSET  = 1'd1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] LONG_THRESHOLD_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_OFFSET_RST  = 16'd1000;

    // events from one button for one scan
    typedef struct packed {
        logic evt_short;
        logic evt_long;
    } t_btn_evt;

    // configuration handed to the button slices
    typedef struct packed {
        logic [CFG_W-1:0] long_threshold;
        logic [CFG_W-1:0] repeat_offset;
    } t_cfg;

endpackage

// ===== rtl/bpc_ifs.sv =====
// ---------------------------------------------------------------------------
// bpc channel interfaces
// valid/ready channels for scans, events and configuration writes
// ---------------------------------------------------------------------------

// scan channel: two button levels and the current tick
interface bpc_scan_if;
    logic                           valid;
    logic                           ready;
    logic                           right_level;
    logic                           left_level;
    logic [bpc_pkg::TICK_W-1:0]     now_tick;

    modport source (output valid, right_level, left_level, now_tick, input ready);
    modport sink   (input valid, right_level, left_level, now_tick, output ready);
endinterface

// event channel: short and long press flags per button
interface bpc_evt_if;
    logic valid;
    logic ready;
    logic right_short;
    logic right_long;
    logic left_short;
    logic left_long;

    modport source (output valid, right_short, right_long, left_short, left_long,
                    input ready);
    modport sink   (input valid, right_short, right_long, left_short, left_long,
                    output ready);
endinterface

// configuration write channel
interface bpc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bpc_pkg::CFG_IDX_W-1:0]   index;
    logic [bpc_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bpc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// bpc_cfg_regs
// holds the long-press threshold and the repeat offset
// ---------------------------------------------------------------------------
module bpc_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bpc_cfg_if.sink              i_cfg,
    output bpc_pkg::t_cfg        o_cfg
);

    logic [bpc_pkg::CFG_W-1:0] r_long_threshold;
    logic [bpc_pkg::CFG_W-1:0] r_repeat_offset;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_threshold <= bpc_pkg::LONG_THRESHOLD_RST;
            r_repeat_offset  <= bpc_pkg::REPEAT_OFFSET_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bpc_pkg::REG_LONG_THRESHOLD: r_long_threshold <= i_cfg.data;
                bpc_pkg::REG_REPEAT_OFFSET:  r_repeat_offset  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg.long_threshold = r_long_threshold;
    assign o_cfg.repeat_offset  = r_repeat_offset;

endmodule

// ===== rtl/bpc_button.sv =====
// ---------------------------------------------------------------------------
// bpc_button
// per-button state and short/long press decision for one scan
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_button (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_level,
    input  logic [bpc_pkg::TICK_W-1:0]    i_now,
    input  bpc_pkg::t_cfg                 i_cfg,
    output bpc_pkg::t_btn_evt             o_evt
);

    logic                          r_prev_level;
    logic                          r_long_flag;
    logic [bpc_pkg::TICK_W-1:0]    r_press_time;

    logic                          n_prev_level;
    logic                          n_long_flag;
    logic [bpc_pkg::TICK_W-1:0]    n_press_time;

    logic                          rise;
    logic [bpc_pkg::TICK_W-1:0]    elapsed;
    logic                          exceeds;
    logic                          fire_long;
    logic                          fire_short;

    // wrapping elapsed time, negative never exceeds the threshold
    assign rise    = i_level & ~r_prev_level;
    assign elapsed = i_now - r_press_time;
    assign exceeds = ~elapsed[bpc_pkg::TICK_W-1] &&
                     (elapsed[bpc_pkg::TICK_W-2:0] >
                      (bpc_pkg::TICK_W-1)'(i_cfg.long_threshold));

    // event decision, long press wins over short release
    assign fire_long  = ~rise & r_prev_level & exceeds;
    assign fire_short = ~fire_long & r_prev_level & ~i_level & ~r_long_flag;

    assign o_evt.evt_long  = fire_long;
    assign o_evt.evt_short = fire_short;

    // next state: press time, flag and level
    always_comb begin
        n_press_time = r_press_time;
        if (rise) begin
            n_press_time = i_now;
        end else if (fire_long) begin
            n_press_time = i_now + bpc_pkg::TICK_W'(i_cfg.repeat_offset);
        end
        n_long_flag  = (r_long_flag | fire_long) & i_level;
        n_prev_level = i_level;
    end

    // state update once per scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_long_flag  <= 1'b0;
            r_press_time <= '0;
        end else if (i_step) begin
            r_prev_level <= n_prev_level;
            r_long_flag  <= n_long_flag;
            r_press_time <= n_press_time;
        end
    end

    // a long press while still held leaves the flag set
    `BPC_ASSERT_NEXT(a_flag_after_long, i_clk, i_rst_n, i_step && fire_long && i_level, r_long_flag)
    // the flag is only ever set while the button was held
    `BPC_ASSERT_NOW(a_flag_needs_level, i_clk, i_rst_n, r_long_flag, r_prev_level)

endmodule

// ===== rtl/button_press_classifier_core.sv =====
// ---------------------------------------------------------------------------
// button_press_classifier_core
// two-button short/long press classifier with auto-repeat
// ---------------------------------------------------------------------------
// Usage:
//   i_scan carries one scan per beat: right and left button levels and the
//   current tick. o_evt returns exactly one event beat per scan, with short
//   and long flags for each button. i_cfg writes the long-press threshold
//   (index 0) and the repeat offset (index 1); it is always ready and must
//   only be written while no scan is in flight.
//   Path: the scan beat is held in the input register, then its event beat is
//   loaded into the event register once that register is free.
//   Throughput: one scan per cycle while o_evt is ready; the input register and the event
//   register are separated by one pass of per-button compare/add logic, and
//   the button state updates on the same edge that loads the event register.
//   Stall: while o_evt is held, at most one more scan is taken into the input
//   register, then i_scan.ready drops until the event beat leaves.
//   Reset: synchronous, active low; both buttons read as released, the
//   threshold returns to 500 ticks and the repeat offset to 1000 ticks.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module button_press_classifier_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpc_scan_if.sink     i_scan,
    bpc_cfg_if.sink      i_cfg,
    bpc_evt_if.source    o_evt
);

    bpc_pkg::t_cfg                     cfg;
    bpc_pkg::t_btn_evt                 btn_evt [bpc_pkg::NUM_BTN];
    logic [bpc_pkg::NUM_BTN-1:0]       levels;

    logic                              r_in_valid;
    logic                              r_right_level;
    logic                              r_left_level;
    logic [bpc_pkg::TICK_W-1:0]        r_now_tick;

    logic                              r_out_valid;
    bpc_pkg::t_btn_evt                 r_right_evt;
    bpc_pkg::t_btn_evt                 r_left_evt;

    logic                              advance;

    // handshake: the held scan moves on when the event register is free
    assign advance      = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_scan.ready = !r_in_valid || advance;

    // configuration registers
    bpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_right_level <= i_scan.right_level;
            r_left_level  <= i_scan.left_level;
            r_now_tick    <= i_scan.now_tick;
        end
    end

    // one slice per button
    assign levels[bpc_pkg::BTN_RIGHT] = r_right_level;
    assign levels[bpc_pkg::BTN_LEFT]  = r_left_level;

    for (genvar b = 0; b < bpc_pkg::NUM_BTN; b++) begin : g_btn
        bpc_button u_btn (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (advance),
            .i_level (levels[b]),
            .i_now   (r_now_tick),
            .i_cfg   (cfg),
            .o_evt   (btn_evt[b])
        );
    end

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_right_evt <= btn_evt[bpc_pkg::BTN_RIGHT];
            r_left_evt  <= btn_evt[bpc_pkg::BTN_LEFT];
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.right_short = r_right_evt.evt_short;
    assign o_evt.right_long  = r_right_evt.evt_long;
    assign o_evt.left_short  = r_left_evt.evt_short;
    assign o_evt.left_long   = r_left_evt.evt_long;

    // a button never reports short and long in the same beat
    `BPC_ASSERT_NOW(a_right_excl, i_clk, i_rst_n, r_out_valid, !(r_right_evt.evt_short && r_right_evt.evt_long))
    `BPC_ASSERT_NOW(a_left_excl, i_clk, i_rst_n, r_out_valid, !(r_left_evt.evt_short && r_left_evt.evt_long))
    // a scan that cannot advance stays in the input register
    `BPC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    // every advancing scan produces an event beat
    `BPC_ASSERT_NEXT(a_adv_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-button short/long press classifier
// ---------------------------------------------------------------------------
// Scans go in on i_scan and event beats are checked on o_evt against an
// in-bench classifier that keeps its own copy of the button state and the
// threshold/offset registers. A short directed table (edges, wrap of the
// signed elapsed time, release after threshold, press time wrap) runs at the
// reset settings, then random hold/release sequences run under several
// register settings, with random idle bursts on the scan side and random
// stalls on the event side, calm at the end.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_SCANS  = 270;

    // event flags of one scan, in port order
    typedef struct packed {
        logic right_short;
        logic right_long;
        logic left_short;
        logic left_long;
    } t_press_evt;

    localparam t_press_evt EV_NONE    = 4'b0000;
    localparam t_press_evt EV_R_SHORT = 4'b1000;
    localparam t_press_evt EV_R_LONG  = 4'b0100;
    localparam t_press_evt EV_L_LONG  = 4'b0001;

    // one row of the directed part
    typedef struct {
        logic                       right;
        logic                       left;
        logic [bpc_pkg::TICK_W-1:0] tick;
        bit                         typed;
        t_press_evt                 evt;
    } t_scan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpc_scan_if scan_ch ();
    bpc_evt_if  evt_ch ();
    bpc_cfg_if  cfg_ch ();

    button_press_classifier_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_ch),
        .i_cfg   (cfg_ch),
        .o_evt   (evt_ch)
    );

    always #1 i_clk = ~i_clk;

    // classifier copy of the block state and registers
    logic [bpc_pkg::CFG_W-1:0]  cfg_threshold = bpc_pkg::LONG_THRESHOLD_RST;
    logic [bpc_pkg::CFG_W-1:0]  cfg_repeat    = bpc_pkg::REPEAT_OFFSET_RST;
    logic                       btn_prev      [bpc_pkg::NUM_BTN] = '{default: 1'b0};
    logic                       btn_held_long [bpc_pkg::NUM_BTN] = '{default: 1'b0};
    logic [bpc_pkg::TICK_W-1:0] btn_press_at  [bpc_pkg::NUM_BTN] = '{default: '0};

    t_press_evt pending_events[$];
    t_scan_row  directed_rows[$];

    // tag of the scan beat currently driven
    bit         scan_typed = 1'b0;
    t_press_evt scan_typed_evt = EV_NONE;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned scans_taken = 0;
    int unsigned events_checked = 0;
    int unsigned shorts_seen = 0;
    int unsigned longs_seen = 0;
    int unsigned settings_used = 1;

    // random sequence state
    logic [bpc_pkg::TICK_W-1:0] tick_now = '0;
    logic                       hold_level [bpc_pkg::NUM_BTN] = '{default: 1'b0};
    int unsigned                hold_left  [bpc_pkg::NUM_BTN] = '{default: 0};

    // classify one scan and advance the button state
    function automatic t_press_evt classify_scan(input logic right, input logic left,
                                                 input logic [bpc_pkg::TICK_W-1:0] tick);
        t_press_evt                 res;
        logic [1:0]                 hit_short;
        logic [1:0]                 hit_long;
        logic                       cur;
        logic [bpc_pkg::TICK_W-1:0] elapsed;
        hit_short = '0;
        hit_long  = '0;
        for (int b = 0; b < bpc_pkg::NUM_BTN; b++) begin
            cur     = (b == bpc_pkg::BTN_RIGHT) ? right : left;
            elapsed = tick - btn_press_at[b];
            if (cur && !btn_prev[b]) begin
                btn_press_at[b] = tick;
            end else if (btn_prev[b] && !elapsed[bpc_pkg::TICK_W-1] &&
                         elapsed > {16'd0, cfg_threshold}) begin
                // long press, push the press time out for auto-repeat
                hit_long[b]      = 1'b1;
                btn_press_at[b]  = tick + {16'd0, cfg_repeat};
                btn_held_long[b] = 1'b1;
            end else if (btn_prev[b] && !cur && !btn_held_long[b]) begin
                hit_short[b] = 1'b1;
            end
            btn_prev[b] = cur;
            if (!cur) begin
                btn_held_long[b] = 1'b0;
            end
        end
        res.right_short = hit_short[bpc_pkg::BTN_RIGHT];
        res.right_long  = hit_long[bpc_pkg::BTN_RIGHT];
        res.left_short  = hit_short[bpc_pkg::BTN_LEFT];
        res.left_long   = hit_long[bpc_pkg::BTN_LEFT];
        return res;
    endfunction

    // event check, register tracking and classification at each edge
    always @(posedge i_clk) begin
        t_press_evt want;
        if (i_rst_n) begin
            if (evt_ch.valid && evt_ch.ready) begin
                events_checked++;
                if (pending_events.size() == 0) begin
                    $error("event beat with no scan waiting");
                    fail_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (evt_ch.right_short !== want.right_short) begin
                        $error("right_short: expected %0b, actual %0b",
                               want.right_short, evt_ch.right_short);
                        fail_count++;
                    end
                    if (evt_ch.right_long !== want.right_long) begin
                        $error("right_long: expected %0b, actual %0b",
                               want.right_long, evt_ch.right_long);
                        fail_count++;
                    end
                    if (evt_ch.left_short !== want.left_short) begin
                        $error("left_short: expected %0b, actual %0b",
                               want.left_short, evt_ch.left_short);
                        fail_count++;
                    end
                    if (evt_ch.left_long !== want.left_long) begin
                        $error("left_long: expected %0b, actual %0b",
                               want.left_long, evt_ch.left_long);
                        fail_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    bpc_pkg::REG_LONG_THRESHOLD: cfg_threshold = cfg_ch.data;
                    bpc_pkg::REG_REPEAT_OFFSET:  cfg_repeat    = cfg_ch.data;
                    default: ;
                endcase
            end
            if (scan_ch.valid && scan_ch.ready) begin
                scans_taken++;
                want = classify_scan(scan_ch.right_level, scan_ch.left_level,
                                     scan_ch.now_tick);
                if (scan_typed) begin
                    want = scan_typed_evt;
                end
                shorts_seen += want.right_short + want.left_short;
                longs_seen  += want.right_long + want.left_long;
                pending_events.push_back(want);
            end
        end
    end

    // event side stalls in bursts
    initial begin
        evt_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                evt_ch.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                evt_ch.ready = 1'b1;
            end
        end
    end

    // cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** button_press_classifier_core: FAILED **");
        $finish;
    end

    task automatic add_row(input logic right, input logic left,
                           input logic [bpc_pkg::TICK_W-1:0] tick,
                           input bit typed, input t_press_evt evt);
        t_scan_row row;
        row.right = right;
        row.left  = left;
        row.tick  = tick;
        row.typed = typed;
        row.evt   = evt;
        directed_rows.push_back(row);
    endtask

    // one scan beat, with an optional idle burst ahead of it
    task automatic send_scan(input logic right, input logic left,
                             input logic [bpc_pkg::TICK_W-1:0] tick,
                             input bit typed, input t_press_evt evt);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            scan_ch.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        scan_ch.valid       = 1'b1;
        scan_ch.right_level = right;
        scan_ch.left_level  = left;
        scan_ch.now_tick    = tick;
        scan_typed          = typed;
        scan_typed_evt      = evt;
        do @(posedge i_clk); while (!scan_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_events();
        scan_ch.valid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
    endtask

    // both registers, back to back, while nothing is in flight
    task automatic set_config(input logic [bpc_pkg::CFG_W-1:0] thr,
                              input logic [bpc_pkg::CFG_W-1:0] rep);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = bpc_pkg::REG_LONG_THRESHOLD;
        cfg_ch.data  = thr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.index = bpc_pkg::REG_REPEAT_OFFSET;
        cfg_ch.data  = rep;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        settings_used++;
    endtask

    // random hold/release runs with a tick stepping on the scale of the threshold
    task automatic random_scans(input int unsigned count);
        int unsigned pick;
        int unsigned span;
        int unsigned b;
        for (int unsigned n = 0; n < count; n++) begin
            span = int'(cfg_threshold) / 3 + 2;
            for (int i = 0; i < bpc_pkg::NUM_BTN; i++) begin
                if (hold_left[i] == 0) begin
                    hold_level[i] = ~hold_level[i];
                    hold_left[i]  = hold_level[i] ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 6);
                end
                hold_left[i]--;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // tick jump anywhere
                tick_now = $urandom();
            end else if (pick < 6) begin
                // tick going backwards
                tick_now = tick_now - $urandom_range(0, span);
            end else if (pick < 10) begin
                // level glitch on one button
                b = $urandom_range(0, 1);
                hold_level[b] = ~hold_level[b];
                tick_now = tick_now + $urandom_range(0, span);
            end else begin
                tick_now = tick_now + $urandom_range(0, span);
            end
            send_scan(hold_level[bpc_pkg::BTN_RIGHT], hold_level[bpc_pkg::BTN_LEFT],
                      tick_now, 1'b0, EV_NONE);
        end
    endtask

    initial begin
        logic [bpc_pkg::CFG_W-1:0] thr;
        logic [bpc_pkg::CFG_W-1:0] rep;
        scan_ch.valid       = 1'b0;
        scan_ch.right_level = 1'b0;
        scan_ch.left_level  = 1'b0;
        scan_ch.now_tick    = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = bpc_pkg::REG_LONG_THRESHOLD;
        cfg_ch.data         = '0;

        // directed scans at reset settings: threshold 500, offset 1000
        add_row(1'b0, 1'b0, 32'h0000_0000, 1'b1, EV_NONE);     // idle after reset
        add_row(1'b1, 1'b0, 32'd100,       1'b0, EV_NONE);     // right pressed
        add_row(1'b1, 1'b0, 32'd600,       1'b0, EV_NONE);     // held exactly threshold
        add_row(1'b1, 1'b0, 32'd601,       1'b1, EV_R_LONG);   // one past threshold
        add_row(1'b1, 1'b0, 32'd1601,      1'b0, EV_NONE);
        add_row(1'b1, 1'b0, 32'd2102,      1'b0, EV_NONE);     // auto-repeat
        add_row(1'b0, 1'b0, 32'd2200,      1'b0, EV_NONE);     // release after long
        add_row(1'b0, 1'b1, 32'd3000,      1'b0, EV_NONE);
        add_row(1'b0, 1'b0, 32'd3100,      1'b0, EV_NONE);     // left short
        add_row(1'b1, 1'b1, 32'hFFFF_FF00, 1'b0, EV_NONE);
        add_row(1'b0, 1'b0, 32'h0000_0100, 1'b1, EV_R_LONG | EV_L_LONG); // release past it
        add_row(1'b1, 1'b0, 32'h0000_1000, 1'b0, EV_NONE);
        add_row(1'b1, 1'b0, 32'h0000_0FFF, 1'b0, EV_NONE);     // negative elapsed
        add_row(1'b0, 1'b0, 32'h0000_0800, 1'b1, EV_R_SHORT);
        add_row(1'b1, 1'b1, 32'h0000_0000, 1'b0, EV_NONE);
        add_row(1'b1, 1'b1, 32'h8000_0000, 1'b1, EV_NONE);     // sign bit of elapsed
        add_row(1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0, EV_NONE);     // largest positive
        add_row(1'b0, 1'b1, 32'h8000_0000, 1'b0, EV_NONE);
        add_row(1'b1, 1'b0, 32'hFFFF_FC00, 1'b0, EV_NONE);
        add_row(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, EV_NONE);     // press time wraps
        add_row(1'b1, 1'b0, 32'd1500,      1'b0, EV_NONE);
        add_row(1'b0, 1'b0, 32'd1501,      1'b0, EV_NONE);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct   = 20;
        stall_pct = 15;
        foreach (directed_rows[i]) begin
            send_scan(directed_rows[i].right, directed_rows[i].left, directed_rows[i].tick,
                      directed_rows[i].typed, directed_rows[i].evt);
        end

        // random phases under several register settings
        tick_now = $urandom();
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            drain_events();
            case (ph)
                0: begin thr = '0;    rep = '0;    gap_pct = 10; stall_pct = 10; end
                1: begin thr = '1;    rep = '1;    gap_pct = 0;  stall_pct = 20; end
                2: begin
                    thr = bpc_pkg::CFG_W'($urandom_range(1, 64));
                    rep = bpc_pkg::CFG_W'($urandom_range(0, 64));
                    gap_pct = 30;
                    stall_pct = 0;
                end
                3: begin
                    thr = bpc_pkg::CFG_W'($urandom());
                    rep = bpc_pkg::CFG_W'($urandom());
                    gap_pct = 5;
                    stall_pct = 30;
                end
                4: begin thr = 16'd1; rep = '1;    gap_pct = 15; stall_pct = 8;  end
                default: begin
                    thr = bpc_pkg::LONG_THRESHOLD_RST;
                    rep = bpc_pkg::REPEAT_OFFSET_RST;
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            set_config(thr, rep);
            random_scans(PHASE_SCANS);
        end

        drain_events();
        repeat (4) @(negedge i_clk);

        $display("checked %0d event beats for %0d scans under %0d register settings",
                 events_checked, scans_taken, settings_used);
        $display("expected %0d short presses and %0d long presses or repeats, %0d cycles",
                 shorts_seen, longs_seen, cycle_count);
        if (fail_count == 0) begin
            $display("** button_press_classifier_core: PASSED **");
        end else begin
            $display("** button_press_classifier_core: FAILED **");
        end
        $finish;
    end

endmodule
